/* rtl/core/sfr_pkg.sv */
`default_nettype none

package sfr_pkg;

	localparam int INPUT_BITS = 16;
	localparam int FRAC_BITS  = 32;
	localparam int INT_PAIRS  = (INPUT_BITS + 1) / 2;
	localparam int STEPS      = INT_PAIRS + FRAC_BITS;
	localparam int PAD_W      = 2 * INT_PAIRS;
	localparam int ROOT_W     = STEPS;
	localparam int REM_W      = STEPS + 1;
	localparam int ACC_W      = REM_W + 2;

	// partial root, partial remainder, and the radicand bits not yet consumed
	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0]  rem;
		logic [PAD_W-1:0]  n;
	} cell_data_t;

endpackage

`default_nettype wire

/* rtl/core/sfr_cell.sv */
`default_nettype none

module sfr_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sfr_pkg::cell_data_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output sfr_pkg::cell_data_t     out_data
);
	import sfr_pkg::*;

	logic                valid_q;
	cell_data_t          data_q;
	cell_data_t          next_data;
	logic [ACC_W-1:0]    acc;
	logic [ACC_W-1:0]    trial;
	logic [ACC_W:0]      diff;

	// one restoring step: bring down the top radicand pair, try 4*root+1
	always_comb begin
		acc   = {in_data.rem, in_data.n[PAD_W-1 -: 2]};
		trial = {1'b0, in_data.root, 2'b01};
		diff  = {1'b0, acc} - {1'b0, trial};
		next_data.n = {in_data.n[PAD_W-3:0], 2'b00};
		if (!diff[ACC_W]) begin
			next_data.rem  = diff[REM_W-1:0];
			next_data.root = {in_data.root[ROOT_W-2:0], 1'b1};
		end else begin
			next_data.rem  = acc[REM_W-1:0];
			next_data.root = {in_data.root[ROOT_W-2:0], 1'b0};
		end
	end

	// a stage takes a new beat when empty or when its own beat moves on
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

/* rtl/core/sqrt_fraction_32bit_core.sv */
// Each accepted radicand passes through a chain of registered cells, one per root bit, before fraction_bits is valid.
// Throughput: one beat per cycle while out_stall is low; each cell of the chain resolves one root bit.
// Empty cells fill while the output is stalled, so bubbles are squeezed out.
// Reset (arst_n low, asynchronous): all cell valid flags clear; data registers keep no reset.
`default_nettype none

module sqrt_fraction_32bit_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [sfr_pkg::INPUT_BITS-1:0] radicand,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [sfr_pkg::FRAC_BITS-1:0]      fraction_bits
);
	import sfr_pkg::*;

	logic       valid_c [STEPS+1];
	logic       ready_c [STEPS+1];
	cell_data_t data_c  [STEPS+1];

	assign valid_c[0]       = in_valid;
	assign in_stall         = !ready_c[0];
	// root and remainder start at zero; the radicand feeds the pair shifter
	assign data_c[0]        = {{ROOT_W{1'b0}}, {REM_W{1'b0}}, PAD_W'(radicand)};

	for (genvar k = 0; k < STEPS; k++) begin : g_cell
		sfr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[k]),
			.in_ready  (ready_c[k]),
			.in_data   (data_c[k]),
			.out_valid (valid_c[k+1]),
			.out_ready (ready_c[k+1]),
			.out_data  (data_c[k+1])
		);
	end

	assign ready_c[STEPS] = !out_stall;
	assign out_valid      = valid_c[STEPS];
	// integer bits of the root drop off: value mod 2^32
	assign fraction_bits  = data_c[STEPS].root[FRAC_BITS-1:0];

endmodule

`default_nettype wire
